### design/lsh_pkg.sv
// shared types and constants for the laplacian sharpening block
`timescale 1ns / 1ps

package lsh_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned PIX_W     = NUM_LANES * CHAN_W;
  localparam int unsigned TAPS      = 4;

  // 9 * 255 needs 12 bits, the signed difference one more
  localparam int unsigned POS_W = CHAN_W + 4;
  localparam int unsigned NEG_W = CHAN_W + 3;
  localparam int unsigned SUM_W = POS_W + 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic             MODE_RESET   = 1'b0;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_KERNEL_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic {
    KERNEL_FOUR  = 1'b0,
    KERNEL_EIGHT = 1'b1
  } kernel_e;

  // where an output pixel is taken from
  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_WINDOW = 2'd1,
    SRC_FILTER = 2'd2,
    SRC_STORE  = 2'd3
  } src_e;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } out_item_t;

endpackage

### design/lsh_row_store.sv
// single-port-write, single-port-read row store with registered read data
`timescale 1ns / 1ps

module lsh_row_store #(
  parameter int unsigned DEPTH = lsh_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WIDTH = lsh_pkg::PIX_W
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/lsh_lane.sv
// one colour channel of the sharpening kernel, clamped to 0..255
`timescale 1ns / 1ps

module lsh_lane (
  input  lsh_pkg::chan_t centre_i,
  input  lsh_pkg::chan_t edge_i   [lsh_pkg::TAPS],
  input  lsh_pkg::chan_t corner_i [lsh_pkg::TAPS],
  input  logic           mode_i,
  output lsh_pkg::chan_t result_o
);

  logic [lsh_pkg::NEG_W-1:0]        edge_sum;
  logic [lsh_pkg::NEG_W-1:0]        corner_sum;
  logic [lsh_pkg::POS_W-1:0]        pos;
  logic [lsh_pkg::NEG_W-1:0]        neg;
  logic signed [lsh_pkg::SUM_W-1:0] diff;

  always_comb begin
    edge_sum   = '0;
    corner_sum = '0;
    for (int t = 0; t < lsh_pkg::TAPS; t++) begin
      edge_sum   = edge_sum + lsh_pkg::NEG_W'(edge_i[t]);
      corner_sum = corner_sum + lsh_pkg::NEG_W'(corner_i[t]);
    end
    if (lsh_pkg::kernel_e'(mode_i) == lsh_pkg::KERNEL_EIGHT) begin
      // centre times nine, all eight neighbours subtracted
      pos = (lsh_pkg::POS_W'(centre_i) << 3) + lsh_pkg::POS_W'(centre_i);
      neg = edge_sum + corner_sum;
    end else begin
      pos = (lsh_pkg::POS_W'(centre_i) << 2) + lsh_pkg::POS_W'(centre_i);
      neg = edge_sum;
    end
    diff = $signed(lsh_pkg::SUM_W'(pos)) - $signed(lsh_pkg::SUM_W'(neg));
    if (diff < 0) begin
      result_o = '0;
    end else if (diff > $signed(lsh_pkg::SUM_W'(lsh_pkg::CHAN_MAX))) begin
      result_o = lsh_pkg::CHAN_MAX;
    end else begin
      result_o = diff[lsh_pkg::CHAN_W-1:0];
    end
  end

endmodule

### design/lsh_out_buf.sv
// two-entry output buffer that decouples the receiver from the pipeline
`timescale 1ns / 1ps

module lsh_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsh_pkg::out_item_t  data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output lsh_pkg::out_item_t  data_o
);

  lsh_pkg::out_item_t slot_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("item pushed into a full output buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("output buffer count out of range");

endmodule

### design/laplacian_sharpen_3x3.sv
// top level: 3x3 laplacian sharpening of an rgb raster stream
//
// input channel: in_valid_i / in_ready_o carry one item per handshake, either a
// pixel (operation_i = 0) or a flush (operation_i = 1). after the last pixel of a
// frame, image_width + 1 flush items drain the pending pixels; the last of them
// has last_pixel_o set and rearms the block for a new frame.
// output channel: out_valid_o / out_ready_i, one sharpened pixel per item.
// configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 width, 1 height,
// 2 kernel mode) and cfg_data_i; always ready. the user must see that it is
// written only while idle; the block does not enforce this. throughput: one
// item per clock while in_ready_o is high. a result goes through the registered
// row store read, then the window, the three channel lanes and the buffer write.
// output stalls: a two-entry output buffer holds results; input ready drops only
// when that buffer is full and stage one holds an item.
// reset: counters, window and output buffer clear, configuration returns to
// 640 x 480 with the four-neighbour kernel. the row stores are not cleared.
`timescale 1ns / 1ps

module laplacian_sharpen_3x3 #(
  parameter int unsigned MAX_WIDTH  = lsh_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lsh_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [lsh_pkg::CHAN_W-1:0] red_i,
  input  logic [lsh_pkg::CHAN_W-1:0] green_i,
  input  logic [lsh_pkg::CHAN_W-1:0] blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lsh_pkg::CHAN_W-1:0] out_red_o,
  output logic [lsh_pkg::CHAN_W-1:0] out_green_o,
  output logic [lsh_pkg::CHAN_W-1:0] out_blue_o,
  output logic                       last_pixel_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [lsh_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned KW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW0 = (KW > RW) ? KW : RW;
  localparam int unsigned DW  = (DW0 > lsh_pkg::CFG_W) ? DW0 : lsh_pkg::CFG_W;
  localparam int unsigned PW  = lsh_pkg::PIX_W;
  localparam int unsigned CW  = lsh_pkg::CHAN_W;
  localparam int unsigned NL  = lsh_pkg::NUM_LANES;

  // configuration
  logic [lsh_pkg::CFG_W-1:0] width_q, height_q;
  logic                      mode_q;
  logic [DW-1:0]             width_ext, height_ext, w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lsh_pkg::WIDTH_RESET;
      height_q <= lsh_pkg::HEIGHT_RESET;
      mode_q   <= lsh_pkg::MODE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lsh_pkg::cfg_idx_e'(cfg_index_i))
        lsh_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        lsh_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        lsh_pkg::CFG_KERNEL_MODE:  mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_ext  = DW'(width_q);
    height_ext = DW'(height_q);
    if (width_ext < DW'(3)) begin
      w_eff = DW'(3);
    end else if (width_ext > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (height_ext < DW'(3)) begin
      h_eff = DW'(3);
    end else if (height_ext > DW'(MAX_HEIGHT)) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = height_ext;
    end
  end

  // stage 0: position counters and item decode
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [KW-1:0] flush_q, flush_d;
  logic          in_fire, is_flush, drain, row_end, last_flush;
  logic          upd_s0, last_s0;
  lsh_pkg::src_e src_s0;
  logic [AW-1:0] rd_addr;

  assign in_fire    = in_valid_i && in_ready_o;
  assign is_flush   = (lsh_pkg::op_e'(operation_i) == lsh_pkg::OP_FLUSH);
  assign drain      = (DW'(row_q) >= h_eff);
  assign row_end    = ((DW'(col_q) + DW'(1)) >= w_eff);
  assign last_flush = (DW'(flush_q) >= w_eff);

  always_comb begin
    upd_s0  = 1'b0;
    last_s0 = 1'b0;
    src_s0  = lsh_pkg::SRC_NONE;
    rd_addr = col_q;
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    if (is_flush) begin
      // a flush counts only once the whole frame is in
      if (drain) begin
        src_s0  = (flush_q == '0) ? lsh_pkg::SRC_WINDOW : lsh_pkg::SRC_STORE;
        rd_addr = AW'(flush_q - KW'(1));
        last_s0 = last_flush;
        if (last_flush) begin
          col_d   = '0;
          row_d   = '0;
          flush_d = '0;
        end else begin
          flush_d = flush_q + KW'(1);
        end
      end
    end else if (!drain) begin
      upd_s0 = 1'b1;
      if (col_q != '0 && row_q != '0) begin
        // border rows and columns pass through
        if (row_q == RW'(1) || col_q == AW'(1) || DW'(col_q) >= w_eff) begin
          src_s0 = lsh_pkg::SRC_WINDOW;
        end else begin
          src_s0 = lsh_pkg::SRC_FILTER;
        end
      end else if (col_q == '0 && row_q >= RW'(2)) begin
        // right edge of the row before
        src_s0 = lsh_pkg::SRC_WINDOW;
      end
      if (row_end) begin
        col_d   = '0;
        row_d   = row_q + RW'(1);
        flush_d = '0;
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
    end else if (in_fire) begin
      col_q   <= col_d;
      row_q   <= row_d;
      flush_q <= flush_d;
    end
  end

  // stage 1 registers
  logic          s1_valid_q, s1_upd_q, s1_last_q, s1_mode_q;
  lsh_pkg::src_e s1_src_q;
  logic [PW-1:0] s1_pix_q;
  logic [AW-1:0] s1_idx_q;
  logic          s1_adv, buf_full, push;

  assign s1_adv     = s1_valid_q && !buf_full;
  assign in_ready_o = !s1_valid_q || !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_upd_q   <= 1'b0;
      s1_src_q   <= lsh_pkg::SRC_NONE;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      s1_upd_q   <= upd_s0;
      s1_src_q   <= src_s0;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q <= last_s0;
      s1_mode_q <= mode_q;
      s1_pix_q  <= {red_i, green_i, blue_i};
      s1_idx_q  <= col_q;
    end
  end

  // row stores: older row gets what the newer row held, newer row gets the pixel
  logic [PW-1:0] older_rd, newer_rd;
  logic          store_wr;

  assign store_wr = s1_adv && s1_upd_q;

  lsh_row_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PW)
  ) u_older_row (
    .clk_i     (clk_i),
    .wr_en_i   (store_wr),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (newer_rd),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (older_rd)
  );

  lsh_row_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PW)
  ) u_newer_row (
    .clk_i     (clk_i),
    .wr_en_i   (store_wr),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (s1_pix_q),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (newer_rd)
  );

  // window: only the left and middle columns are held, the right one comes
  // from the row store reads and the stage one pixel
  logic [PW-1:0] win_q [3][2];
  logic [PW-1:0] nw    [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = win_q[i][0];
      nw[i][1] = win_q[i][1];
    end
    nw[0][2] = older_rd;
    nw[1][2] = newer_rd;
    nw[2][2] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (store_wr) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= nw[i][2];
      end
    end
  end

  // one lane per colour channel, red in the top byte
  lsh_pkg::chan_t filt [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    localparam int unsigned SH = (NL - 1 - l) * CW;
    lsh_pkg::chan_t edges   [lsh_pkg::TAPS];
    lsh_pkg::chan_t corners [lsh_pkg::TAPS];

    assign edges[0]   = nw[0][1][SH +: CW];
    assign edges[1]   = nw[2][1][SH +: CW];
    assign edges[2]   = nw[1][0][SH +: CW];
    assign edges[3]   = nw[1][2][SH +: CW];
    assign corners[0] = nw[0][0][SH +: CW];
    assign corners[1] = nw[0][2][SH +: CW];
    assign corners[2] = nw[2][0][SH +: CW];
    assign corners[3] = nw[2][2][SH +: CW];

    lsh_lane u_lane (
      .centre_i (nw[1][1][SH +: CW]),
      .edge_i   (edges),
      .corner_i (corners),
      .mode_i   (s1_mode_q),
      .result_o (filt[l])
    );
  end

  // merge: pick the source for the output pixel
  logic [PW-1:0]      out_pix;
  lsh_pkg::out_item_t push_item, pop_item;

  always_comb begin
    case (s1_src_q)
      lsh_pkg::SRC_FILTER: out_pix = {filt[0], filt[1], filt[2]};
      lsh_pkg::SRC_STORE:  out_pix = newer_rd;
      default:             out_pix = win_q[1][1];
    endcase
    push_item.red   = out_pix[2*CW +: CW];
    push_item.green = out_pix[CW +: CW];
    push_item.blue  = out_pix[0 +: CW];
    push_item.last  = s1_last_q;
  end

  assign push = s1_adv && (s1_src_q != lsh_pkg::SRC_NONE);

  lsh_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (pop_item)
  );

  assign out_red_o    = pop_item.red;
  assign out_green_o  = pop_item.green;
  assign out_blue_o   = pop_item.blue;
  assign last_pixel_o = pop_item.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_flush && drain && last_flush) |=>
      (row_q == '0 && col_q == '0 && flush_q == '0))
    else $error("counters not cleared after the final flush item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !in_fire)
    else $error("item taken while stage one is held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |->
      (s1_src_q == lsh_pkg::SRC_WINDOW || s1_src_q == lsh_pkg::SRC_STORE))
    else $error("last pixel flagged on an item that is not a flush");

endmodule

### dv/tb_top.sv
// self-checking testbench for laplacian_sharpen_3x3 with its own pixel predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STORE_DEPTH  = lsh_pkg::MAX_WIDTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  lsh_pkg::op_e              in_op     = lsh_pkg::OP_PIXEL;
  lsh_pkg::chan_t            in_red    = '0;
  lsh_pkg::chan_t            in_green  = '0;
  lsh_pkg::chan_t            in_blue   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  lsh_pkg::chan_t            out_red;
  lsh_pkg::chan_t            out_green;
  lsh_pkg::chan_t            out_blue;
  logic                      out_last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  lsh_pkg::cfg_idx_e         cfg_index = lsh_pkg::CFG_IMAGE_WIDTH;
  logic [lsh_pkg::CFG_W-1:0] cfg_data  = '0;

  // predictor state
  logic [lsh_pkg::PIX_W-1:0] older_row [STORE_DEPTH] = '{default: '0};
  logic [lsh_pkg::PIX_W-1:0] newer_row [STORE_DEPTH] = '{default: '0};
  logic [lsh_pkg::PIX_W-1:0] win [3][3] = '{default: '0};
  int unsigned               col_cnt    = 0;
  int unsigned               row_cnt    = 0;
  int unsigned               flush_cnt  = 0;
  logic [lsh_pkg::CFG_W-1:0] cfg_width  = lsh_pkg::WIDTH_RESET;
  logic [lsh_pkg::CFG_W-1:0] cfg_height = lsh_pkg::HEIGHT_RESET;
  lsh_pkg::kernel_e          cfg_mode   = lsh_pkg::kernel_e'(lsh_pkg::MODE_RESET);

  lsh_pkg::out_item_t sharpened_q[$];
  int unsigned error_count   = 0;
  int unsigned stall_count   = 0;
  int unsigned hold_cycles   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned work_items    = 0;

  laplacian_sharpen_3x3 dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .operation_i  (in_op),
    .red_i        (in_red),
    .green_i      (in_green),
    .blue_i       (in_blue),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_red_o    (out_red),
    .out_green_o  (out_green),
    .out_blue_o   (out_blue),
    .last_pixel_o (out_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(logic [lsh_pkg::CFG_W-1:0] raw, int unsigned hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic int lane_of(logic [lsh_pkg::PIX_W-1:0] p, int unsigned sh);
    return int'(p[sh +: lsh_pkg::CHAN_W]);
  endfunction

  function automatic lsh_pkg::chan_t sharpen_lane(int unsigned sh);
    int centre;
    int edge_total;
    int corners;
    int acc;
    centre     = lane_of(win[1][1], sh);
    edge_total = lane_of(win[0][1], sh) + lane_of(win[2][1], sh)
               + lane_of(win[1][0], sh) + lane_of(win[1][2], sh);
    if (cfg_mode == lsh_pkg::KERNEL_EIGHT) begin
      corners = lane_of(win[0][0], sh) + lane_of(win[0][2], sh)
              + lane_of(win[2][0], sh) + lane_of(win[2][2], sh);
      acc = 9 * centre - edge_total - corners;
    end else begin
      acc = 5 * centre - edge_total;
    end
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return lsh_pkg::chan_t'(acc);
  endfunction

  function automatic void push_pixel(logic [lsh_pkg::PIX_W-1:0] p, logic last);
    sharpened_q.push_back(lsh_pkg::out_item_t'{
      red:   p[2*lsh_pkg::CHAN_W +: lsh_pkg::CHAN_W],
      green: p[lsh_pkg::CHAN_W +: lsh_pkg::CHAN_W],
      blue:  p[0 +: lsh_pkg::CHAN_W],
      last:  last});
  endfunction

  function automatic void apply_cfg(lsh_pkg::cfg_idx_e idx, logic [lsh_pkg::CFG_W-1:0] data);
    unique case (idx)
      lsh_pkg::CFG_IMAGE_WIDTH:  cfg_width = data;
      lsh_pkg::CFG_IMAGE_HEIGHT: cfg_height = data;
      lsh_pkg::CFG_KERNEL_MODE:  cfg_mode = lsh_pkg::kernel_e'(data[0]);
      default: ;
    endcase
  endfunction

  // steps the predictor by one accepted item and queues the pixel it releases
  function automatic void advance_sharpener(lsh_pkg::op_e op, lsh_pkg::chan_t r,
                                            lsh_pkg::chan_t g, lsh_pkg::chan_t b);
    int unsigned               w;
    int unsigned               h;
    int unsigned               idx;
    int                        i;
    logic [lsh_pkg::PIX_W-1:0] pix;
    logic [lsh_pkg::PIX_W-1:0] top;
    logic [lsh_pkg::PIX_W-1:0] mid;
    logic [lsh_pkg::PIX_W-1:0] right_prev;
    logic [lsh_pkg::PIX_W-1:0] res;
    w = clamp_dim(cfg_width, lsh_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(cfg_height, lsh_pkg::MAX_HEIGHT_DEF);
    if (op == lsh_pkg::OP_FLUSH) begin
      // a flush before the frame is complete is dropped
      if (row_cnt < h) return;
      if (flush_cnt == 0) res = win[1][2];
      else res = (flush_cnt - 1 < STORE_DEPTH) ? newer_row[flush_cnt - 1] : '0;
      if (flush_cnt >= w) begin
        push_pixel(res, 1'b1);
        row_cnt = 0;
        col_cnt = 0;
        flush_cnt = 0;
      end else begin
        push_pixel(res, 1'b0);
        flush_cnt++;
      end
      return;
    end
    // pixels arriving while the frame drains are dropped
    if (row_cnt >= h) return;
    pix = {r, g, b};
    idx = (col_cnt < STORE_DEPTH) ? col_cnt : STORE_DEPTH - 1;
    top = older_row[idx];
    mid = newer_row[idx];
    right_prev = win[1][2];
    older_row[idx] = mid;
    newer_row[idx] = pix;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    if (col_cnt >= 1 && row_cnt >= 1) begin
      if (row_cnt == 1 || col_cnt == 1 || col_cnt >= w) res = win[1][1];
      else res = {sharpen_lane(2 * lsh_pkg::CHAN_W), sharpen_lane(lsh_pkg::CHAN_W),
                  sharpen_lane(0)};
      push_pixel(res, 1'b0);
    end else if (col_cnt == 0 && row_cnt >= 2) begin
      push_pixel(right_prev, 1'b0);
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt++;
      flush_cnt = 0;
    end else begin
      col_cnt++;
    end
  endfunction

  function automatic lsh_pkg::chan_t pick_level();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return lsh_pkg::chan_t'($urandom_range(255));
    endcase
  endfunction

  // valid stays up after acceptance so back-to-back items need no second assignment
  task automatic send_item(lsh_pkg::op_e op, lsh_pkg::chan_t r, lsh_pkg::chan_t g,
                           lsh_pkg::chan_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (!in_ready);
    advance_sharpener(op, r, g, b);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (sharpened_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lsh_pkg::cfg_idx_e idx, logic [lsh_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
  endtask

  task automatic configure(logic [lsh_pkg::CFG_W-1:0] w, logic [lsh_pkg::CFG_W-1:0] h,
                           lsh_pkg::kernel_e mode);
    logic [lsh_pkg::CFG_W-1:0] mode_word;
    // upper bits of the mode word carry noise, only bit 0 counts
    mode_word = lsh_pkg::CFG_W'($urandom);
    mode_word[0] = mode;
    drain_outputs();
    write_reg(lsh_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(lsh_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(lsh_pkg::CFG_KERNEL_MODE, mode_word);
    cfg_valid <= 1'b0;
  endtask

  // one whole frame plus its drain, with stray items mixed in
  task automatic send_frame(int unsigned noise_pct);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = clamp_dim(cfg_width, lsh_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(cfg_height, lsh_pkg::MAX_HEIGHT_DEF);
    for (n = 0; n < w * h; n++) begin
      if ($urandom_range(99) < noise_pct)
        send_item(lsh_pkg::OP_FLUSH, pick_level(), pick_level(), pick_level());
      send_item(lsh_pkg::OP_PIXEL, pick_level(), pick_level(), pick_level());
    end
    for (n = 0; n <= w; n++) begin
      if ($urandom_range(99) < noise_pct)
        send_item(lsh_pkg::OP_PIXEL, pick_level(), pick_level(), pick_level());
      send_item(lsh_pkg::OP_FLUSH, pick_level(), pick_level(), pick_level());
    end
    work_items += w * h + w + 1;
  endtask

  // smallest frame: clamping both ways, a stray flush and a stray pixel
  task automatic test_four_neighbour();
    int unsigned r;
    int unsigned c;
    configure(12'd3, 12'd3, lsh_pkg::KERNEL_FOUR);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (r == 1 && c == 0) send_item(lsh_pkg::OP_FLUSH, '1, '1, '1);
        if (r == 1 && c == 1) send_item(lsh_pkg::OP_PIXEL, 8'd255, 8'd0, 8'd100);
        else send_item(lsh_pkg::OP_PIXEL, 8'd0, 8'd255, lsh_pkg::chan_t'(90 + 3 * r + c));
      end
    end
    send_item(lsh_pkg::OP_FLUSH, '0, '0, '0);
    send_item(lsh_pkg::OP_PIXEL, 8'hAA, 8'h55, 8'hFF);
    for (c = 0; c < 3; c++) send_item(lsh_pkg::OP_FLUSH, '0, '0, '0);
  endtask

  task automatic test_eight_neighbour();
    int unsigned r;
    int unsigned c;
    configure(12'd3, 12'd3, lsh_pkg::KERNEL_EIGHT);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (r == 1 && c == 1) send_item(lsh_pkg::OP_PIXEL, 8'd0, 8'd255, 8'd60);
        else if ((r + c) % 2 == 1) send_item(lsh_pkg::OP_PIXEL, 8'd255, 8'd0, 8'd10);
        else send_item(lsh_pkg::OP_PIXEL, 8'd128, 8'd64, 8'd120);
      end
    end
    for (c = 0; c <= 3; c++) send_item(lsh_pkg::OP_FLUSH, '1, '1, '1);
  endtask

  // width and height shrink while a frame is in flight
  task automatic test_geometry_change();
    int unsigned n;
    configure(12'd8, 12'd6, lsh_pkg::kernel_e'($urandom_range(1)));
    for (n = 0; n < 3 * 8 + 6; n++)
      send_item(lsh_pkg::OP_PIXEL, pick_level(), pick_level(), pick_level());
    drain_outputs();
    // column 6 now lies past the end of the row
    write_reg(lsh_pkg::CFG_IMAGE_WIDTH, 12'd4);
    cfg_valid <= 1'b0;
    for (n = 0; n < 1 + 4; n++)
      send_item(lsh_pkg::OP_PIXEL, pick_level(), pick_level(), pick_level());
    drain_outputs();
    write_reg(lsh_pkg::CFG_IMAGE_HEIGHT, 12'd5);
    cfg_valid <= 1'b0;
    for (n = 0; n <= 4; n++)
      send_item(lsh_pkg::OP_FLUSH, pick_level(), pick_level(), pick_level());
  endtask

  task automatic test_random_frames(int unsigned quota);
    int unsigned               start;
    logic [lsh_pkg::CFG_W-1:0] w;
    logic [lsh_pkg::CFG_W-1:0] h;
    start = work_items;
    while (work_items - start < quota) begin
      case ($urandom_range(9))
        0:       w = lsh_pkg::CFG_W'($urandom_range(2));
        1:       w = lsh_pkg::CFG_W'($urandom_range(40, 13));
        default: w = lsh_pkg::CFG_W'($urandom_range(12, 3));
      endcase
      if ($urandom_range(9) == 0) h = lsh_pkg::CFG_W'($urandom_range(2));
      else h = lsh_pkg::CFG_W'($urandom_range(7, 3));
      configure(w, h, lsh_pkg::kernel_e'($urandom_range(1)));
      send_frame(4);
    end
  endtask

  // receiver stops long enough for the block to fill and hold off its input
  task automatic test_output_stall();
    configure(12'd16, 12'd5, lsh_pkg::KERNEL_EIGHT);
    hold_cycles = HOLD_CYCLES;
    send_frame(0);
  endtask

  // register values below the legal range, and one wider frame
  task automatic test_size_extremes();
    configure(12'd0, 12'd1, lsh_pkg::KERNEL_EIGHT);
    send_frame(0);
    configure(12'd2, 12'd0, lsh_pkg::KERNEL_FOUR);
    send_frame(0);
    configure(12'd40, 12'd3, lsh_pkg::KERNEL_FOUR);
    send_frame(0);
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_output
    lsh_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sharpened_q.size() == 0) begin
        $error("output item with nothing expected: r %0d g %0d b %0d last %0b",
               out_red, out_green, out_blue, out_last);
        error_count++;
      end else begin
        want = sharpened_q.pop_front();
        if (out_red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, out_red);
          error_count++;
        end
        if (out_green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, out_green);
          error_count++;
        end
        if (out_blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, out_blue);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last_pixel: expected %0b, got %0b", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("laplacian_sharpen_3x3: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 75;
    test_four_neighbour();
    test_eight_neighbour();
    test_geometry_change();
    test_random_frames(320);

    send_idle_pct = 75;
    recv_idle_pct = 18;
    test_random_frames(320);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random_frames(320);
    test_size_extremes();

    drain_outputs();
    if (error_count == 0 && sharpened_q.size() == 0) begin
      $display("laplacian_sharpen_3x3: match");
    end else begin
      $display("laplacian_sharpen_3x3: mismatch");
    end
    $finish;
  end

endmodule
